FILE: hw/rtl/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg: shared types, constants and helpers of the PM2.5 calibrator
// Network weights, result kind codes and the int8 rounding/requant functions.
// ----------------------------------------------------------------------------
package pmc_pkg;

  // Fixed field widths
  localparam int PM_W   = 16;
  localparam int ENV_W  = 13;
  localparam int OUT_W  = 17;
  localparam int KIND_W = 2;

  // Default number of fraction bits on the inputs
  localparam int INPUT_FRAC_BITS_DEF = 4;

  // Result kind codes
  localparam logic [KIND_W-1:0] KIND_NET  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PASS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ZERO = 2'd2;

  // Network shape
  localparam int N_IN  = 3;
  localparam int N_H1  = 8;
  localparam int N_H2  = 4;

  // Fixed weights and biases
  localparam int W_L1 [N_H1][N_IN] = '{
    '{59, -4, 0}, '{26, 0, 64}, '{0, 0, 0}, '{0, 0, 0},
    '{0, 0, 0},   '{0, 0, 0},   '{0, 0, 0}, '{0, 0, 0}
  };
  localparam int B_L1 [N_H1] = '{271, -5120, -64, -64, -64, -64, -64, -64};
  localparam int W_L2 [N_H2][N_H1] = '{
    '{64, 0, 0, 0, 0, 0, 0, 0},
    '{0, 64, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0}
  };
  localparam int B_L2 [N_H2] = '{0, 0, -128, -128};
  localparam int W_OUT [N_H2] = '{127, -85, 0, 0};
  localparam int B_OUT = 0;

  // Side info that rides along the pipe with each sample
  typedef struct packed {
    logic [OUT_W-1:0]  value;      // pass-through or zero value
    logic [KIND_W-1:0] kind;
    logic              distorted;
  } side_t;

  // Output of the front end: quantized inputs and side info
  typedef struct packed {
    logic signed [7:0] q_pm;
    logic signed [7:0] q_tc;
    logic signed [7:0] q_rh;
    side_t             side;
  } front_t;

  // round(x / 2^sh), half away from zero, then saturate to int8
  function automatic logic signed [7:0] round_sat8(input logic signed [16:0] x,
                                                   input int sh);
    logic signed [17:0] xs;
    logic [17:0]        mag;
    logic [17:0]        half;
    logic [17:0]        r;
    logic signed [7:0]  res;
    xs   = 18'(x);
    mag  = (xs < 0) ? 18'(-xs) : 18'(xs);
    half = (18'd1 << sh) >> 1;
    r    = (mag + half) >> sh;
    if (xs < 0) begin
      res = (r > 18'd128) ? -8'sd128 : 8'(-r);
    end else begin
      res = (r > 18'd127) ? 8'sd127 : 8'(r);
    end
    return res;
  endfunction

  // ReLU, add rounding, shift right 6, saturate (result is never negative)
  function automatic logic [6:0] requant(input int acc);
    int s;
    s = (acc + 32) >>> 6;
    if (acc < 0) return 7'd0;
    if (s > 127) return 7'd127;
    return 7'(s);
  endfunction

endpackage

FILE: hw/rtl/pm25_int8_mlp_calibrator.sv
// ----------------------------------------------------------------------------
// pm25_int8_mlp_calibrator: int8 3-8-4-1 network PM2.5 calibrator
// Registers A-D lie between input and result; one sample per cycle unless stalled.
// Stages: quantize, hidden layer 1, hidden layer 2, output layer/select.
// A full stage holds under output backpressure; nothing is lost or repeated.
// Synchronous active-low reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module pm25_int8_mlp_calibrator
  import pmc_pkg::*;
#(
  parameter int INPUT_FRAC_BITS = INPUT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // pm_raw[15:0], temperature[28:16], humidity[41:29]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pm_calibrated[16:0]
  output logic [2:0]  out_tuser   // result_kind[1:0], humidity_distorted[2]
);

  // Stage valid and ready
  logic v_a_r, v_b_r, v_c_r, v_d_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  assign rdy_d     = !v_d_r || out_tready;
  assign rdy_c     = !v_c_r || rdy_d;
  assign rdy_b     = !v_b_r || rdy_c;
  assign rdy_a     = !v_a_r || rdy_b;
  assign in_tready = rdy_a;

  // Front end
  front_t front;

  pmc_front #(
    .INPUT_FRAC_BITS(INPUT_FRAC_BITS)
  ) u_front (
    .pm_raw     (in_tdata[15:0]),
    .temperature(in_tdata[28:16]),
    .humidity   (in_tdata[41:29]),
    .front      (front)
  );

  // Stage A: quantized inputs
  logic signed [7:0] q_a_r [N_IN];
  side_t             side_a_r;

  // Stage B: hidden layer 1
  logic [6:0] h1_nxt [N_H1];
  logic [6:0] h1_r   [N_H1];
  side_t      side_b_r;

  // Stage C: hidden layer 2
  logic [6:0] h2_nxt [N_H2];
  logic [6:0] h2_r   [N_H2];
  side_t      side_c_r;

  // Stage D: output register
  logic [OUT_W-1:0]  value_nxt;
  logic [OUT_W-1:0]  value_r;
  logic [KIND_W-1:0] kind_r;
  logic              dist_r;

  // Layer 1 MAC and requant
  always_comb begin
    int acc;
    for (int i = 0; i < N_H1; i++) begin
      acc = B_L1[i];
      for (int j = 0; j < N_IN; j++) begin
        acc = acc + int'(q_a_r[j]) * W_L1[i][j];
      end
      h1_nxt[i] = requant(acc);
    end
  end

  // Layer 2 MAC and requant
  always_comb begin
    int acc;
    for (int i = 0; i < N_H2; i++) begin
      acc = B_L2[i];
      for (int j = 0; j < N_H1; j++) begin
        acc = acc + int'({1'b0, h1_r[j]}) * W_L2[i][j];
      end
      h2_nxt[i] = requant(acc);
    end
  end

  // Output layer, clamp at zero, pick result by kind
  always_comb begin
    int acc;
    acc = B_OUT;
    for (int i = 0; i < N_H2; i++) begin
      acc = acc + int'({1'b0, h2_r[i]}) * W_OUT[i];
    end
    if (side_c_r.kind != KIND_NET) begin
      value_nxt = side_c_r.value;
    end else if (acc < 0) begin
      value_nxt = '0;
    end else begin
      value_nxt = acc[OUT_W-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else begin
      if (rdy_a) v_a_r <= in_tvalid;
      if (rdy_b) v_b_r <= v_a_r;
      if (rdy_c) v_c_r <= v_b_r;
      if (rdy_d) v_d_r <= v_c_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      q_a_r[0] <= front.q_pm;
      q_a_r[1] <= front.q_tc;
      q_a_r[2] <= front.q_rh;
      side_a_r <= front.side;
    end
    if (rdy_b) begin
      h1_r     <= h1_nxt;
      side_b_r <= side_a_r;
    end
    if (rdy_c) begin
      h2_r     <= h2_nxt;
      side_c_r <= side_b_r;
    end
    if (rdy_d) begin
      value_r <= value_nxt;
      kind_r  <= side_c_r.kind;
      dist_r  <= side_c_r.distorted;
    end
  end

  assign out_tvalid = v_d_r;
  assign out_tdata  = {7'd0, value_r};
  assign out_tuser  = {dist_r, kind_r};

endmodule

FILE: hw/rtl/pmc_front.sv
// ----------------------------------------------------------------------------
// pmc_front: input classification and int8 quantization
// Decides the result kind, the pass-through value and the distortion flag,
// and quantizes the three inputs for the network.
// ----------------------------------------------------------------------------
module pmc_front
  import pmc_pkg::*;
#(
  parameter int INPUT_FRAC_BITS = INPUT_FRAC_BITS_DEF
) (
  input  logic signed [PM_W-1:0]  pm_raw,
  input  logic signed [ENV_W-1:0] temperature,
  input  logic signed [ENV_W-1:0] humidity,
  output front_t                  front
);

  localparam int ONE = 1 << INPUT_FRAC_BITS;
  localparam int SHL = (INPUT_FRAC_BITS <= 6) ? 6 - INPUT_FRAC_BITS : 0;
  localparam int SHR = (INPUT_FRAC_BITS > 6) ? INPUT_FRAC_BITS - 6 : 0;

  int          pm_i;
  int          tc_i;
  int          rh_i;
  logic [31:0] pm_u;
  logic [31:0] pass_val;
  logic        rh_in_range;
  logic        out_of_range;

  assign pm_i = int'(pm_raw);
  assign tc_i = int'(temperature);
  assign rh_i = int'(humidity);
  assign pm_u = 32'(pm_i);

  // Raw value scaled to 1/64 ug/m3
  assign pass_val = (INPUT_FRAC_BITS <= 6) ? (pm_u << SHL) : (pm_u >> SHR);

  assign rh_in_range  = (rh_i >= 0) && (rh_i <= 100 * ONE);
  assign out_of_range = (pm_i > 508 * ONE) || (tc_i < -40 * ONE) ||
                        (tc_i > 125 * ONE) || !rh_in_range;

  // Classification and quantization to int8
  always_comb begin
    front.q_pm = round_sat8(17'(pm_raw), INPUT_FRAC_BITS + 2);
    front.q_tc = round_sat8(17'(temperature), INPUT_FRAC_BITS);
    front.q_rh = round_sat8(17'(humidity), INPUT_FRAC_BITS);
    front.side.distorted = (pm_i > 0) && rh_in_range && (rh_i > 60 * ONE) &&
                           (pm_i > 10 * ONE);
    if (pm_i < 0) begin
      front.side.kind  = KIND_ZERO;
      front.side.value = '0;
    end else if (out_of_range) begin
      front.side.kind  = KIND_PASS;
      front.side.value = pass_val[OUT_W-1:0];
    end else begin
      front.side.kind  = KIND_NET;
      front.side.value = '0;
    end
  end

endmodule

FILE: hw/rtl/pmc_checker.sv
// ----------------------------------------------------------------------------
// pmc_checker: port-level checks for the PM2.5 calibrator
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module pmc_checker
  import pmc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // An empty output stage lets the whole pipe move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Negative raw gives zero, and the kind code is a defined one
  a_kind_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[1:0] == KIND_NET || out_tuser[1:0] == KIND_PASS ||
                    (out_tuser[1:0] == KIND_ZERO && out_tdata[16:0] == '0)))
    else $error("bad result kind or nonzero forced value");

  // Stalled input is only seen while a sample is offered
  a_in_offer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |-> out_tvalid)
    else $error("input stalled with nothing to deliver");

endmodule

bind pm25_int8_mlp_calibrator pmc_checker u_pmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
